// ===== hdl/gicdf_pkg.sv =====
// package for the gaussian inverse cdf sampler: formats, constants, polynomial coefficients
// no dependencies
package gicdf_pkg;

  localparam int unsigned ProbBitsDef = 32;
  localparam int unsigned FracBitsDef = 16;

  localparam int unsigned DevW    = 20;
  localparam int unsigned SampleW = 19;
  localparam int unsigned MeanW   = 32;
  localparam int unsigned StdevW  = 31;
  localparam int unsigned CfgW    = 32;

  // configuration register indexes
  typedef enum logic [0:0] {
    CfgMean  = 1'b0,
    CfgStdev = 1'b1
  } cfg_idx_e;

  // q in Q.48
  localparam logic [48:0] HalfQ48 = 49'h0_8000_0000_0000;
  localparam logic [48:0] OneQ48  = 49'h1_0000_0000_0000;
  localparam logic [48:0] LimQ48  = 49'd33495522;
  localparam logic [28:0] TwoLn2Q28 = 29'd372130559;

  localparam logic [28:0] Cp0 = 29'd86498610;
  localparam logic [28:0] Cp1 = 29'd268435456;
  localparam logic [28:0] Cp2 = 29'd91869911;
  localparam logic [28:0] Cp3 = 29'd5482290;
  localparam logic [28:0] Cp4 = 29'd12177;
  localparam logic [28:0] Cq0 = 29'd26668650;
  localparam logic [28:0] Cq1 = 29'd157996162;
  localparam logic [28:0] Cq2 = 29'd142567000;
  localparam logic [28:0] Cq3 = 29'd27793204;
  localparam logic [28:0] Cq4 = 29'd1035106;

  localparam int signed SampleMin = -262144;
  localparam int signed SampleMax = 262143;

endpackage

// ===== hdl/gaussian_inverse_cdf_sampler_unit.sv =====
// Throughput: one item per cycle while the output is not stalled.
// The depth is set by the 30 squaring steps of the log2 unit, the 32 steps of the square
// root and the 56 restoring steps of the P/Q divider, each a pipeline stage of its own.
// A stall holds the whole pipe. Reset clears valid bits and sets mean 0, stdev 1.0;
// data registers are not reset.
// depends on gicdf_pkg
module gaussian_inverse_cdf_sampler_unit #(
  parameter int unsigned PROB_BITS = gicdf_pkg::ProbBitsDef,
  parameter int unsigned FRAC_BITS = gicdf_pkg::FracBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [0:0]                       cfg_idx_i,
  input  logic [gicdf_pkg::CfgW-1:0]       cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [31:0]                      uniform_p_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [gicdf_pkg::DevW-1:0]    deviate_q16_o,
  output logic signed [gicdf_pkg::SampleW-1:0] sample_o
);

  localparam int unsigned NLog  = 30;
  localparam int unsigned NSqrt = 32;
  localparam int unsigned NDiv  = 56;
  localparam int unsigned Sh    = 28 - FRAC_BITS;
  localparam int unsigned S     = FRAC_BITS + 16;
  localparam int unsigned UBits = (PROB_BITS < 32) ? PROB_BITS : 32;
  // internal deviate holds +-6.0 in Q.FRAC_BITS
  localparam int unsigned DevIW = FRAC_BITS + 4;
  localparam int unsigned TotW  = FRAC_BITS + 37;
  localparam int unsigned SmpW  = TotW + 1;
  // stage counts
  localparam int unsigned LogBase  = 1;             // after fold, normalize
  localparam int unsigned SqBase   = LogBase + NLog + 2;
  localparam int unsigned PolyBase = SqBase + NSqrt + 1;
  localparam int unsigned DivBase  = PolyBase + 9;
  localparam int unsigned Depth    = DivBase + NDiv + 5;
  localparam int unsigned FlagW    = DivBase + NDiv + 1;

  logic signed [gicdf_pkg::MeanW-1:0] mean_q;
  logic [gicdf_pkg::StdevW-1:0] stdev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q  <= '0;
      stdev_q <= gicdf_pkg::StdevW'(65536);
    end else if (cfg_we_i) begin
      unique case (gicdf_pkg::cfg_idx_e'(cfg_idx_i))
        gicdf_pkg::CfgMean:  mean_q  <= cfg_data_i;
        gicdf_pkg::CfgStdev: stdev_q <= cfg_data_i[gicdf_pkg::StdevW-1:0];
        default: ;
      endcase
    end
  end

  // global pipeline advance
  logic adv;
  logic [Depth-1:0] vld_q;
  assign adv = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end
  assign out_valid_o = vld_q[Depth-1];

  // stage 0: fold and clamp
  logic [UBits-1:0] u_pb;
  logic [48:0] p0, q0f, q0;
  logic neg0, half0;
  always_comb begin
    u_pb = uniform_p_i[UBits-1:0];
    p0   = 49'(u_pb) << (48 - PROB_BITS);
    q0f  = (p0 > gicdf_pkg::HalfQ48) ? gicdf_pkg::OneQ48 - p0 : p0;
    q0   = (q0f < gicdf_pkg::LimQ48) ? gicdf_pkg::LimQ48 : q0f;
    neg0 = p0 < gicdf_pkg::HalfQ48;
    half0 = q0 == gicdf_pkg::HalfQ48;
  end

  // per-item flags: negative tail, exact half
  logic [FlagW-1:0] neg_q, half_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      neg_q  <= {neg_q[FlagW-2:0], neg0};
      half_q <= {half_q[FlagW-2:0], half0};
    end
  end

  logic [47:0] qs_q;
  always_ff @(posedge clk_i) if (adv) qs_q <= q0[47:0];

  // stage 1: normalize to Q.30 mantissa
  logic [5:0] e1;
  logic [47:0] xn1;
  always_comb begin
    e1 = '0;
    for (int i = 0; i < 48; i++) if (qs_q[i]) e1 = 6'(i);
    xn1 = qs_q << (6'd47 - e1);
  end
  logic [30:0] lx_q [NLog+1];
  logic [5:0]  le_q [NLog+1];
  logic [29:0] lf_q [NLog+1];
  always_ff @(posedge clk_i) if (adv) begin
    lx_q[0] <= xn1[47:17];
    le_q[0] <= e1;
    lf_q[0] <= '0;
  end

  // log2 by squaring, one bit per stage
  for (genvar g = 0; g < NLog; g++) begin : g_log
    logic [61:0] sq;
    logic [31:0] xs;
    assign sq = 62'(lx_q[g]) * 62'(lx_q[g]);
    assign xs = sq[61:30];
    always_ff @(posedge clk_i) if (adv) begin
      le_q[g+1] <= le_q[g];
      if (xs[31]) begin
        lx_q[g+1] <= xs[31:1];
        lf_q[g+1] <= lf_q[g] | (30'd1 << (29 - g));
      end else begin
        lx_q[g+1] <= xs[30:0];
        lf_q[g+1] <= lf_q[g];
      end
    end
  end

  // L * 2ln2 then >>28 and sqrt operand
  logic [35:0] l_q;
  logic [35:0] l_d;
  assign l_d = ({6'd48 - le_q[NLog], 30'd0}) - 36'(lf_q[NLog]);
  always_ff @(posedge clk_i) if (adv) l_q <= l_d;
  logic [64:0] lm;
  logic [36:0] t30;
  assign lm = 65'(l_q) * 65'(gicdf_pkg::TwoLn2Q28);
  assign t30 = lm[64:28];
  logic [63:0] sv_q [NSqrt+1];
  logic [63:0] sr_q [NSqrt+1];
  always_ff @(posedge clk_i) if (adv) begin
    sv_q[0] <= 64'(t30 >> 2) << 28;
    sr_q[0] <= '0;
  end

  // restoring square root, one result bit per stage
  for (genvar g = 0; g < NSqrt; g++) begin : g_sqrt
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * g);
    logic [63:0] tr;
    assign tr = sr_q[g] + Bit;
    always_ff @(posedge clk_i) if (adv) begin
      if (sv_q[g] >= tr) begin
        sv_q[g+1] <= sv_q[g] - tr;
        sr_q[g+1] <= (sr_q[g] >> 1) + Bit;
      end else begin
        sv_q[g+1] <= sv_q[g];
        sr_q[g+1] <= sr_q[g] >> 1;
      end
    end
  end
  logic [31:0] y0;
  assign y0 = sr_q[NSqrt][31:0];

  // Horner for P and Q in parallel, one step per stage
  logic [31:0] py_q [5];
  logic [33:0] pp_q [5];
  logic [33:0] qq_q [5];
  always_ff @(posedge clk_i) if (adv) begin
    py_q[0] <= y0;
    pp_q[0] <= 34'(gicdf_pkg::Cp4);
    qq_q[0] <= 34'(gicdf_pkg::Cq4);
  end
  for (genvar g = 0; g < 4; g++) begin : g_horn
    localparam logic [28:0] Pc [4] = '{gicdf_pkg::Cp3, gicdf_pkg::Cp2, gicdf_pkg::Cp1,
                                       gicdf_pkg::Cp0};
    localparam logic [28:0] Qc [4] = '{gicdf_pkg::Cq3, gicdf_pkg::Cq2, gicdf_pkg::Cq1,
                                       gicdf_pkg::Cq0};
    logic [65:0] pm, qm;
    assign pm = 66'(pp_q[g]) * 66'(py_q[g]);
    assign qm = 66'(qq_q[g]) * 66'(py_q[g]);
    always_ff @(posedge clk_i) if (adv) begin
      py_q[g+1] <= py_q[g];
      pp_q[g+1] <= 34'(pm >> 28) + 34'(Pc[g]);
      qq_q[g+1] <= 34'(qm >> 28) + 34'(Qc[g]);
    end
  end
  // padding stages to keep valid depth aligned
  logic [31:0] pyd_q [4];
  logic [33:0] ppd_q [4];
  logic [33:0] qqd_q [4];
  always_ff @(posedge clk_i) if (adv) begin
    pyd_q[0] <= py_q[4];
    ppd_q[0] <= pp_q[4];
    qqd_q[0] <= qq_q[4];
    for (int i = 1; i < 4; i++) begin
      pyd_q[i] <= pyd_q[i-1];
      ppd_q[i] <= ppd_q[i-1];
      qqd_q[i] <= qqd_q[i-1];
    end
  end

  // restoring divide (pm << 28) / qm, one quotient bit per stage
  // the top six dividend bits seed the remainder, the low 56 are shifted in
  logic [NDiv-1:0] dn_q [NDiv+1];
  logic [33:0] dd_q [NDiv+1];
  logic [34:0] dr_q [NDiv+1];
  logic [NDiv-1:0] dqb_q [NDiv+1];
  logic [31:0] dy_q [NDiv+1];
  always_ff @(posedge clk_i) if (adv) begin
    dn_q[0]  <= {ppd_q[3][27:0], 28'd0};
    dd_q[0]  <= qqd_q[3];
    dr_q[0]  <= 35'(ppd_q[3][33:28]);
    dqb_q[0] <= '0;
    dy_q[0]  <= pyd_q[3];
  end
  for (genvar g = 0; g < NDiv; g++) begin : g_div
    logic [35:0] rs;
    logic ge;
    assign rs = {dr_q[g], dn_q[g][NDiv - 1 - g]};
    assign ge = rs >= 36'(dd_q[g]);
    always_ff @(posedge clk_i) if (adv) begin
      dn_q[g+1]  <= dn_q[g];
      dd_q[g+1]  <= dd_q[g];
      dy_q[g+1]  <= dy_q[g];
      dr_q[g+1]  <= ge ? 35'(rs - 36'(dd_q[g])) : rs[34:0];
      dqb_q[g+1] <= {dqb_q[g][NDiv-2:0], ge};
    end
  end

  // difference, sign, rounding
  localparam logic [NDiv:0] SixL = (NDiv+1)'(6) << FRAC_BITS;
  logic signed [NDiv+1:0] dif;
  logic dneg;
  logic [NDiv:0] dmag, rmag;
  logic [DevIW-1:0] mag6;
  always_comb begin
    dif  = $signed({1'b0, (NDiv+1)'(dy_q[NDiv])}) - $signed({2'b0, dqb_q[NDiv]});
    dneg = dif[NDiv+1];
    dmag = dneg ? (NDiv+1)'(-dif) : dif[NDiv:0];
    rmag = (dmag + ((NDiv+1)'(1) << (Sh - 1))) >> Sh;
    mag6 = (rmag > SixL) ? DevIW'(SixL) : DevIW'(rmag);
  end
  logic signed [DevIW-1:0] dev_q;
  logic dev_n;
  assign dev_n = half_q[DivBase+NDiv] ? 1'b0 : (neg_q[DivBase+NDiv] ^ dneg);
  always_ff @(posedge clk_i) if (adv) begin
    if (half_q[DivBase+NDiv]) dev_q <= '0;
    else dev_q <= dev_n ? -$signed(mag6) : $signed(mag6);
  end

  // scale and offset
  logic signed [TotW-1:0] tot_q;
  logic signed [DevIW-1:0] dev2_q;
  always_ff @(posedge clk_i) if (adv) begin
    tot_q  <= TotW'(dev_q) * $signed({1'b0, stdev_q})
              + (TotW'(mean_q) <<< FRAC_BITS);
    dev2_q <= dev_q;
  end
  logic [TotW-1:0] amag;
  logic signed [SmpW-1:0] smp;
  always_comb begin
    amag = tot_q[TotW-1] ? TotW'(-tot_q) : tot_q;
    smp  = tot_q[TotW-1] ? -$signed({1'b0, amag >> S}) : $signed({1'b0, amag >> S});
  end
  logic signed [gicdf_pkg::SampleW-1:0] smp_q;
  logic signed [DevIW-1:0] dev3_q;
  always_ff @(posedge clk_i) if (adv) begin
    if (smp < SmpW'(gicdf_pkg::SampleMin)) smp_q <= gicdf_pkg::SampleW'(gicdf_pkg::SampleMin);
    else if (smp > SmpW'(gicdf_pkg::SampleMax))
      smp_q <= gicdf_pkg::SampleW'(gicdf_pkg::SampleMax);
    else smp_q <= smp[gicdf_pkg::SampleW-1:0];
    dev3_q <= dev2_q;
  end
  logic signed [DevIW-1:0] dev4_q;
  logic signed [gicdf_pkg::SampleW-1:0] smp4_q;
  always_ff @(posedge clk_i) if (adv) begin
    dev4_q <= dev3_q;
    smp4_q <= smp_q;
  end
  assign deviate_q16_o = gicdf_pkg::DevW'(dev4_q);
  assign sample_o      = smp4_q;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_o))
    else $error("output changed under stall");
  a_dev_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (deviate_q16_o <= (6 <<< FRAC_BITS)) &&
                    (deviate_q16_o >= -(6 <<< FRAC_BITS)))
    else $error("deviate out of range");
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output stall");

endmodule

// ===== tb/tb_top.sv =====
// testbench for gaussian_inverse_cdf_sampler_unit: drives uniform values and config writes,
// predicts deviate and sample in fixed point and checks every output transfer
// depends on gicdf_pkg and the sampler rtl
class sample_scoreboard;
  logic signed [19:0] exp_dev_q[$];
  logic signed [18:0] exp_smp_q[$];
  int mismatches = 0;
  int orphans = 0;

  function void note_input(logic signed [19:0] dev, logic signed [18:0] smp);
    exp_dev_q.push_back(dev);
    exp_smp_q.push_back(smp);
  endfunction

  function void check_output(logic signed [19:0] dev, logic signed [18:0] smp);
    logic signed [19:0] ed;
    logic signed [18:0] es;
    if (exp_dev_q.size() == 0) begin
      orphans++;
      if (mismatches + orphans <= 10)
        $display("output with no expectation: dev %0d smp %0d", dev, smp);
      return;
    end
    ed = exp_dev_q.pop_front();
    es = exp_smp_q.pop_front();
    if (ed !== dev || es !== smp) begin
      mismatches++;
      if (mismatches + orphans <= 10)
        $display("mismatch: dev exp %0d got %0d, sample exp %0d got %0d", ed, dev, es, smp);
    end
  endfunction

  function int pending();
    return exp_dev_q.size();
  endfunction
endclass

module tb_top;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_idx_i = gicdf_pkg::CfgMean;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [31:0] uniform_p_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [19:0] deviate_q16_o;
  logic signed [18:0] sample_o;

  gaussian_inverse_cdf_sampler_unit i_dut (.*);

  sample_scoreboard sb = new();
  logic signed [31:0] cur_mean = 0;
  logic [30:0] cur_stdev = 31'd65536;
  int send_idle = 15;
  int recv_idle = 60;
  int quiet_cycles = 0;
  localparam int WatchLimit = 20000;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] minus_log2(logic [63:0] q);
    int e;
    logic [63:0] x, frac;
    e = 47;
    frac = 0;
    while (e > 0 && q[e] == 1'b0) e--;
    if (e >= 30) x = q >> (e - 30);
    else x = q << (30 - e);
    for (int i = 1; i <= 30; i++) begin
      x = (x * x) >> 30;
      if (x >= (64'd2 << 30)) begin
        x >>= 1;
        frac |= 64'd1 << (30 - i);
      end
    end
    return (64'(48 - e) << 30) - frac;
  endfunction

  task automatic predict_sample(input logic [31:0] u, output logic signed [19:0] dev_o,
                                output logic signed [18:0] smp_o);
    logic [63:0] p, q, mag, lg, t30, y, pm, qm, r;
    logic signed [63:0] d, dev, total, smp;
    bit neg;
    p = 64'(u) << 16;
    q = (p > 64'(gicdf_pkg::HalfQ48)) ? 64'(gicdf_pkg::OneQ48) - p : p;
    if (q < 64'(gicdf_pkg::LimQ48)) q = 64'(gicdf_pkg::LimQ48);
    mag = 0;
    neg = 0;
    if (q != 64'(gicdf_pkg::HalfQ48)) begin
      lg = minus_log2(q);
      t30 = (lg * 64'(gicdf_pkg::TwoLn2Q28)) >> 28;
      y = int_sqrt((t30 >> 2) << 28);
      pm = (64'(gicdf_pkg::Cp4) * y) >> 28;
      pm = ((pm + 64'(gicdf_pkg::Cp3)) * y) >> 28;
      pm = ((pm + 64'(gicdf_pkg::Cp2)) * y) >> 28;
      pm = ((pm + 64'(gicdf_pkg::Cp1)) * y) >> 28;
      pm = pm + 64'(gicdf_pkg::Cp0);
      qm = (64'(gicdf_pkg::Cq4) * y) >> 28;
      qm = ((qm + 64'(gicdf_pkg::Cq3)) * y) >> 28;
      qm = ((qm + 64'(gicdf_pkg::Cq2)) * y) >> 28;
      qm = ((qm + 64'(gicdf_pkg::Cq1)) * y) >> 28;
      qm = qm + 64'(gicdf_pkg::Cq0);
      r = (pm << 28) / qm;
      d = $signed(y) - $signed(r);
      neg = (p < 64'(gicdf_pkg::HalfQ48));
      if (d < 0) begin
        neg = !neg;
        mag = -d;
      end else begin
        mag = d;
      end
      mag = (mag + (64'd1 << 11)) >> 12;
      if (mag > (64'd6 << 16)) mag = 64'd6 << 16;
    end
    dev = neg ? -$signed(mag) : $signed(mag);
    total = dev * $signed({33'd0, cur_stdev}) + 64'(cur_mean) * 64'sd65536;
    if (total < 0) smp = -$signed(64'(-total) >> 32);
    else smp = $signed(64'(total) >> 32);
    if (smp < gicdf_pkg::SampleMin) smp = gicdf_pkg::SampleMin;
    if (smp > gicdf_pkg::SampleMax) smp = gicdf_pkg::SampleMax;
    dev_o = dev[19:0];
    smp_o = smp[18:0];
  endtask

  // receiver side and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid_o && !out_stall_i) sb.check_output(deviate_q16_o, sample_o);
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  initial begin
    wait (quiet_cycles >= WatchLimit);
    $display("gaussian_inverse_cdf_sampler_unit regression: fail");
    $finish;
  end

  task automatic write_reg(input gicdf_pkg::cfg_idx_e idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == gicdf_pkg::CfgMean) cur_mean = val;
    else cur_stdev = val[30:0];
  endtask

  task automatic send_uniform(input logic [31:0] u);
    logic signed [19:0] ed;
    logic signed [18:0] es;
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    uniform_p_i <= u;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_sample(u, ed, es);
    sb.note_input(ed, es);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_uniform();
    case ($urandom_range(5))
      0: return $urandom_range(255);
      1: return 32'hFFFF_FFFF - $urandom_range(255);
      2: return 32'h8000_0000 + $urandom_range(64) - 32;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] directed [$];
    directed = '{32'h0, 32'h1, 32'h1FF, 32'h200, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0001, 32'hFFFF_FFFF, 32'hFFFF_FE00, 32'h4000_0000,
                 32'hC000_0000, 32'h0001_0000, 32'hFFFE_FFFF, 32'h5555_5555,
                 32'hAAAA_AAAA, 32'h028F_5C29, 32'h7FFF_FF00, 32'h8000_0100};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_uniform(directed[i]);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(gicdf_pkg::CfgMean, 32'h8000_0000);
          write_reg(gicdf_pkg::CfgStdev, 32'h7FFF_FFFF);
        end
        1: begin
          write_reg(gicdf_pkg::CfgMean, 32'h7FFF_FFFF);
          write_reg(gicdf_pkg::CfgStdev, 32'd0);
        end
        2: begin
          write_reg(gicdf_pkg::CfgMean, 32'hFFFF_8000);
          write_reg(gicdf_pkg::CfgStdev, 32'd65536);
        end
        3: begin
          write_reg(gicdf_pkg::CfgMean, $urandom);
          write_reg(gicdf_pkg::CfgStdev, $urandom & 32'h7FFF_FFFF);
        end
        4: begin
          write_reg(gicdf_pkg::CfgMean, $urandom);
          write_reg(gicdf_pkg::CfgStdev, $urandom_range(1 << 26));
        end
        default: begin
          write_reg(gicdf_pkg::CfgMean, 32'h0);
          write_reg(gicdf_pkg::CfgStdev, 32'd65536);
        end
      endcase
      if (ph < 2) begin send_idle = 15; recv_idle = 60; end
      else if (ph < 4) begin send_idle = 60; recv_idle = 15; end
      else begin send_idle = 0; recv_idle = 0; end
      foreach (directed[i]) if (ph < 2) send_uniform(directed[i]);
      repeat (120) send_uniform(rand_uniform());
      drain();
    end
    if (sb.mismatches == 0 && sb.orphans == 0 && sb.pending() == 0)
      $display("gaussian_inverse_cdf_sampler_unit regression: pass");
    else
      $display("gaussian_inverse_cdf_sampler_unit regression: fail");
    $finish;
  end
endmodule

// ===== gaussian_inverse_cdf_sampler_unit.f =====
hdl/gicdf_pkg.sv
hdl/gaussian_inverse_cdf_sampler_unit.sv
tb/tb_top.sv
